// File: src/gwl_pkg.sv
// ----------------------------------------------------------------------------
// gwl_pkg: shared types, constants and microcode for the grid window layout
// Holds the control word and status flag types that pass between the
// sequencer and the datapath, and the microprogram table itself.
// ----------------------------------------------------------------------------
package gwl_pkg;

    localparam int MAX_PORTS   = 32;
    localparam int CNT_W       = 6;     // window counts, rows, windows left
    localparam int COL_W       = 3;     // column count, at most seven
    localparam int PIX_W       = 12;    // pixel coordinates and sizes
    localparam int DVD_W       = 14;    // divider dividend and quotient
    localparam int DSR_W       = 6;     // divider divisor and remainder
    localparam int DIV_STEPS   = DVD_W / 2;
    localparam int DIV_CNT_W   = 3;
    localparam int PC_W        = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    localparam logic [PIX_W-1:0] RESET_WIDTH  = 12'd320;
    localparam logic [PIX_W-1:0] RESET_HEIGHT = 12'd240;

    // configuration register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,      // offer s_tready, load the count on a transfer
        OP_COL_STEP,    // grow the column count until c*(c+1) > n
        OP_DIV_N,       // start n / c
        OP_ROWS,        // take rows and remainder, set up the first row
        OP_DIV_H,       // start ceil(height / rows)
        OP_PH,          // take the cell height
        OP_ROW_INIT,    // windows in this row, clip the row height
        OP_DIV_W,       // start ceil(width / windows in row)
        OP_PW,          // take the cell width
        OP_EMIT,        // load one result into the output register
        OP_ROW_END      // advance to the next row
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_COL_SHORT,
        COND_DIV_BUSY,
        COND_OUT_BUSY,
        COND_ROW_MORE,
        COND_ROW_NEXT
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic col_short;
        logic div_busy;
        logic out_busy;
        logic row_more;
        logic row_next;
    } flags_t;

    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_COL      = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV_N    = 4'd2;
    localparam logic [PC_W-1:0] PC_WAIT_N   = 4'd3;
    localparam logic [PC_W-1:0] PC_ROWS     = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_H    = 4'd5;
    localparam logic [PC_W-1:0] PC_WAIT_H   = 4'd6;
    localparam logic [PC_W-1:0] PC_PH       = 4'd7;
    localparam logic [PC_W-1:0] PC_ROW_INIT = 4'd8;
    localparam logic [PC_W-1:0] PC_DIV_W    = 4'd9;
    localparam logic [PC_W-1:0] PC_WAIT_W   = 4'd10;
    localparam logic [PC_W-1:0] PC_PW       = 4'd11;
    localparam logic [PC_W-1:0] PC_OUT_WAIT = 4'd12;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd13;
    localparam logic [PC_W-1:0] PC_ROW_END  = 4'd14;
    localparam logic [PC_W-1:0] PC_DONE     = 4'd15;

    // Microprogram: a taken condition jumps to target, otherwise fall through.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t uw;
        unique case (pc)
            PC_IDLE:     uw = '{op: OP_ACCEPT,   cond: COND_NO_INPUT,  target: PC_IDLE};
            PC_COL:      uw = '{op: OP_COL_STEP, cond: COND_COL_SHORT, target: PC_COL};
            PC_DIV_N:    uw = '{op: OP_DIV_N,    cond: COND_NONE,      target: PC_IDLE};
            PC_WAIT_N:   uw = '{op: OP_NOP,      cond: COND_DIV_BUSY,  target: PC_WAIT_N};
            PC_ROWS:     uw = '{op: OP_ROWS,     cond: COND_NONE,      target: PC_IDLE};
            PC_DIV_H:    uw = '{op: OP_DIV_H,    cond: COND_NONE,      target: PC_IDLE};
            PC_WAIT_H:   uw = '{op: OP_NOP,      cond: COND_DIV_BUSY,  target: PC_WAIT_H};
            PC_PH:       uw = '{op: OP_PH,       cond: COND_NONE,      target: PC_IDLE};
            PC_ROW_INIT: uw = '{op: OP_ROW_INIT, cond: COND_NONE,      target: PC_IDLE};
            PC_DIV_W:    uw = '{op: OP_DIV_W,    cond: COND_NONE,      target: PC_IDLE};
            PC_WAIT_W:   uw = '{op: OP_NOP,      cond: COND_DIV_BUSY,  target: PC_WAIT_W};
            PC_PW:       uw = '{op: OP_PW,       cond: COND_NONE,      target: PC_IDLE};
            PC_OUT_WAIT: uw = '{op: OP_NOP,      cond: COND_OUT_BUSY,  target: PC_OUT_WAIT};
            PC_EMIT:     uw = '{op: OP_EMIT,     cond: COND_ROW_MORE,  target: PC_OUT_WAIT};
            PC_ROW_END:  uw = '{op: OP_ROW_END,  cond: COND_ROW_NEXT,  target: PC_ROW_INIT};
            PC_DONE:     uw = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PC_IDLE};
        endcase
        return uw;
    endfunction

endpackage

// File: src/gwl_divider.sv
// ----------------------------------------------------------------------------
// gwl_divider: iterative restoring divider, two quotient bits per cycle
// Unsigned DVD_W-bit dividend over DSR_W-bit divisor; busy from start through
// DIV_STEPS steps, then quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module gwl_divider
    import gwl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DSR_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;

    logic [DSR_W:0]       trial_a, trial_b;
    logic [DSR_W-1:0]     rem_a;
    logic                 bit_a, bit_b;

    always_comb begin
        // first restoring step
        trial_a = {rem_reg, quo_reg[DVD_W-1]};
        bit_a   = (trial_a >= {1'b0, dsr_reg});
        rem_a   = bit_a ? DSR_W'(trial_a - {1'b0, dsr_reg}) : trial_a[DSR_W-1:0];
        // second restoring step
        trial_b = {rem_a, quo_reg[DVD_W-2]};
        bit_b   = (trial_b >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-3:0], bit_a, bit_b};
            rem_next = bit_b ? DSR_W'(trial_b - {1'b0, dsr_reg}) : trial_b[DSR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/gwl_sequencer.sv
// ----------------------------------------------------------------------------
// gwl_sequencer: step counter and microcode table
// Fetches one control word per cycle and takes its conditional jump.
// ----------------------------------------------------------------------------
module gwl_sequencer
    import gwl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output uword_t uword
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    always_comb begin
        uword = ucode_rom(pc_reg);
        unique case (uword.cond)
            COND_NONE:      take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_INPUT:  take = !flags.in_valid;
            COND_COL_SHORT: take = flags.col_short;
            COND_DIV_BUSY:  take = flags.div_busy;
            COND_OUT_BUSY:  take = flags.out_busy;
            COND_ROW_MORE:  take = flags.row_more;
            COND_ROW_NEXT:  take = flags.row_next;
            default:        take = 1'b0;
        endcase
        pc_next = take ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: src/gwl_datapath.sv
// ----------------------------------------------------------------------------
// gwl_datapath: layout registers, shared divider and output register
// Executes one operation per control word and reports status flags back.
// ----------------------------------------------------------------------------
module gwl_datapath
    import gwl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  op_t                   op,
    output flags_t                flags,
    input  logic [PIX_W-1:0]      screen_width,
    input  logic [PIX_W-1:0]      screen_height,
    input  logic                  in_valid,
    input  logic [CNT_W-1:0]      window_count,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [PIX_W-1:0]      win_x,
    output logic [PIX_W-1:0]      win_y,
    output logic [PIX_W-1:0]      win_width,
    output logic [PIX_W-1:0]      win_height,
    output logic                  last_window
);

    logic [CNT_W-1:0] n_reg, n_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] rows_reg, rows_next;     // rows still to lay out
    logic [CNT_W-1:0] left_reg, left_next;     // windows still to emit
    logic [COL_W-1:0] cnt_reg, cnt_next;       // windows left in this row
    logic [PIX_W-1:0] rem_h_reg, rem_h_next;
    logic [PIX_W-1:0] rem_w_reg, rem_w_next;
    logic [PIX_W-1:0] ph_reg, ph_next;
    logic [PIX_W-1:0] pw_reg, pw_next;
    logic [PIX_W-1:0] x_reg, x_next;
    logic [PIX_W-1:0] y_reg, y_next;

    logic             ov_reg, ov_next;
    logic [PIX_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [PIX_W-1:0] ow_reg, ow_next, oh_reg, oh_next;
    logic             ol_reg, ol_next;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DSR_W-1:0] div_dsr;
    logic             div_busy;
    logic [DVD_W-1:0] div_quo;
    logic [DSR_W-1:0] div_rem;

    logic [CNT_W-1:0] n_sat;
    logic [CNT_W-1:0] col_prod;
    logic             col_ok;
    logic [PIX_W-1:0] ph_clip, pw_clip;

    gwl_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        if (window_count == '0) begin
            n_sat = CNT_W'(1);
        end else if (window_count > CNT_W'(MAX_PORTS)) begin
            n_sat = CNT_W'(MAX_PORTS);
        end else begin
            n_sat = window_count;
        end
        // c >= n/c holds exactly when c*(c+1) > n
        col_prod = CNT_W'({{(CNT_W-COL_W){1'b0}}, col_reg}
                   * ({{(CNT_W-COL_W){1'b0}}, col_reg} + 1'b1));
        col_ok   = (col_prod > n_reg);
        ph_clip  = (ph_reg > rem_h_reg) ? rem_h_reg : ph_reg;
        pw_clip  = (pw_reg > rem_w_reg) ? rem_w_reg : pw_reg;
    end

    always_comb begin
        n_next     = n_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        rem_h_next = rem_h_reg;
        rem_w_next = rem_w_reg;
        ph_next    = ph_reg;
        pw_next    = pw_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ov_next    = ov_reg && !out_ready;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        ow_next    = ow_reg;
        oh_next    = oh_reg;
        ol_next    = ol_reg;
        div_start  = 1'b0;
        div_dvd    = DVD_W'({{(DVD_W-CNT_W){1'b0}}, n_reg});
        div_dsr    = DSR_W'({{(DSR_W-COL_W){1'b0}}, col_reg});

        unique case (op)
            OP_NOP: begin
            end
            OP_ACCEPT: begin
                if (in_valid) begin
                    n_next   = n_sat;
                    col_next = COL_W'(1);
                end
            end
            OP_COL_STEP: begin
                if (!col_ok) begin
                    col_next = col_reg + 1'b1;
                end
            end
            OP_DIV_N: begin
                div_start = 1'b1;
            end
            OP_ROWS: begin
                rows_next  = (div_quo == '0) ? CNT_W'(1) : div_quo[CNT_W-1:0];
                col_next   = col_reg + COL_W'(div_rem != '0);
                left_next  = n_reg;
                rem_h_next = screen_height;
                y_next     = '0;
            end
            OP_DIV_H: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({2'b00, screen_height})
                          + DVD_W'({{(DVD_W-CNT_W){1'b0}}, rows_reg}) - 1'b1;
                div_dsr   = DSR_W'(rows_reg);
            end
            OP_PH: begin
                ph_next = div_quo[PIX_W-1:0];
            end
            OP_ROW_INIT: begin
                cnt_next   = (left_reg < CNT_W'(col_reg)) ? left_reg[COL_W-1:0] : col_reg;
                ph_next    = ph_clip;
                rem_h_next = rem_h_reg - ph_clip;
                rem_w_next = screen_width;
                x_next     = '0;
            end
            OP_DIV_W: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({2'b00, screen_width})
                          + DVD_W'({{(DVD_W-COL_W){1'b0}}, cnt_reg}) - 1'b1;
                div_dsr   = DSR_W'({{(DSR_W-COL_W){1'b0}}, cnt_reg});
            end
            OP_PW: begin
                pw_next = div_quo[PIX_W-1:0];
            end
            OP_EMIT: begin
                ov_next    = 1'b1;
                ox_next    = x_reg;
                oy_next    = y_reg;
                ow_next    = pw_clip;
                oh_next    = ph_reg;
                // nothing follows: end of row and either last row or no windows left
                ol_next    = (cnt_reg == COL_W'(1))
                          && ((rows_reg == CNT_W'(1)) || (left_reg == CNT_W'(1)));
                pw_next    = pw_clip;
                rem_w_next = rem_w_reg - pw_clip;
                x_next     = x_reg + pw_clip;
                left_next  = left_reg - 1'b1;
                cnt_next   = cnt_reg - 1'b1;
            end
            OP_ROW_END: begin
                y_next    = y_reg + ph_reg;
                rows_next = rows_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        flags.in_valid  = in_valid;
        flags.col_short = !col_ok;
        flags.div_busy  = div_busy;
        flags.out_busy  = ov_reg && !out_ready;
        flags.row_more  = (cnt_reg != COL_W'(1));
        flags.row_next  = (rows_reg != CNT_W'(1)) && (left_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
        n_reg     <= n_next;
        col_reg   <= col_next;
        rows_reg  <= rows_next;
        left_reg  <= left_next;
        cnt_reg   <= cnt_next;
        rem_h_reg <= rem_h_next;
        rem_w_reg <= rem_w_next;
        ph_reg    <= ph_next;
        pw_reg    <= pw_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ow_reg    <= ow_next;
        oh_reg    <= oh_next;
        ol_reg    <= ol_next;
    end

    assign out_valid   = ov_reg;
    assign win_x       = ox_reg;
    assign win_y       = oy_reg;
    assign win_width   = ow_reg;
    assign win_height  = oh_reg;
    assign last_window = ol_reg;

endmodule

// File: src/grid_window_layout_top.sv
// ----------------------------------------------------------------------------
// grid_window_layout_top: tiles the screen into a grid of windows
// Takes a window count and streams out one rectangle per window, row-major.
// ----------------------------------------------------------------------------
// One input transfer carries a window count (0 is taken as 1, anything above
// 32 as 32); the block then emits one result transfer per window in row-major
// order, with m_tlast high on the final one. One request is handled at a time.
// The column count before the remainder correction is at most 6. With no
// back-pressure the time a request takes is set by the shared divider, which
// retires two quotient bits per cycle and is used for two divisions per
// request plus one per row, and by the two-step emit loop of the microcode.
// Screen width and height are written through the cfg port (index 0 width,
// index 1 height, reset 320 x 240) and must only change between requests.
// ----------------------------------------------------------------------------
module grid_window_layout_top
    import gwl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [5:0] window_count, [7:6] zero
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] win_x, [23:12] win_y,
                                              // [35:24] win_width, [47:36] win_height
    output logic                   m_tlast,   // last_window
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [PIX_W-1:0]       cfg_wdata
);

    logic [PIX_W-1:0] scr_w_reg, scr_w_next;
    logic [PIX_W-1:0] scr_h_reg, scr_h_next;

    uword_t           uword;
    flags_t           flags;

    logic [PIX_W-1:0] win_x, win_y, win_width, win_height;

    // Configuration registers: write straight through, no read-back.
    always_comb begin
        scr_w_next = scr_w_reg;
        scr_h_next = scr_h_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_WIDTH:  scr_w_next = cfg_wdata;
                CFG_IDX_HEIGHT: scr_h_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= RESET_WIDTH;
            scr_h_reg <= RESET_HEIGHT;
        end else begin
            scr_w_reg <= scr_w_next;
            scr_h_reg <= scr_h_next;
        end
    end

    // Microcode sequencer: one control word per cycle.
    gwl_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    // Datapath: counts, running offsets, the divider and the output register.
    gwl_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (uword.op),
        .flags         (flags),
        .screen_width  (scr_w_reg),
        .screen_height (scr_h_reg),
        .in_valid      (s_tvalid),
        .window_count  (s_tdata[CNT_W-1:0]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .win_x         (win_x),
        .win_y         (win_y),
        .win_width     (win_width),
        .win_height    (win_height),
        .last_window   (m_tlast)
    );

    // Offer the input only on the idle step of the microprogram.
    assign s_tready = (uword.op == OP_ACCEPT);
    assign m_tdata  = {win_height, win_width, win_y, win_x};

    // A taken request blocks the next transfer, as the idle step is left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Every rectangle stays inside the configured screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, win_x} + {1'b0, win_width} <= {1'b0, scr_w_reg}))
        else $error("window exceeds screen width");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, win_y} + {1'b0, win_height} <= {1'b0, scr_h_reg}))
        else $error("window exceeds screen height");

    // The divider is never restarted while a division is still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        flags.div_busy |-> !((uword.op == OP_DIV_N) || (uword.op == OP_DIV_H)
                          || (uword.op == OP_DIV_W)))
        else $error("divider restarted while busy");

endmodule
